// ===== rtl/core/cbpf_pkg.sv =====
package cbpf_pkg;

   // fixed number formats
   localparam int IN_W             = 16;
   localparam int LIMIT_W          = 16;
   localparam int MAX_SUBDIV_DEPTH = 5;
   localparam int COORD_FRAC_BITS  = 4;
   localparam int INT_FRAC         = COORD_FRAC_BITS + MAX_SUBDIV_DEPTH;
   localparam int OUT_W            = 22;

   // internal coordinate, difference, product and metric widths
   localparam int CW        = IN_W + MAX_SUBDIV_DEPTH;
   localparam int DW        = CW + 1;
   localparam int PW        = 2 * DW;
   localparam int CRW       = PW + 1;
   localparam int THR_SHIFT = 4 * INT_FRAC - 8;
   localparam int TW        = LIMIT_W + THR_SHIFT;
   localparam int SQ_W      = (TW + 1) / 2;
   localparam int MW        = 2 * SQ_W + 1;

   // subdivision stack
   localparam int STACK_DEPTH = MAX_SUBDIV_DEPTH;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int LVL_W       = $clog2(MAX_SUBDIV_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_MOVE  = 2'd0,
      CMD_LINE  = 2'd1,
      CMD_CUBIC = 2'd2,
      CMD_END   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CURSOR,
      S_FINAL,
      S_TEST,
      S_WAIT,
      S_LEAF,
      S_POP
   } state_type;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      coord_type x2;
      coord_type y2;
      coord_type x3;
      coord_type y3;
   } seg_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      seg_type          seg;
   } stack_entry_type;

   typedef struct packed {
      logic done;
      logic flat;
   } flat_res_type;

endpackage

// ===== rtl/core/cbpf_flat_test.sv =====
module cbpf_flat_test (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  cbpf_pkg::seg_type          seg,
   input  logic [cbpf_pkg::LIMIT_W-1:0] limit,
   output cbpf_pkg::flat_res_type     res
);
   import cbpf_pkg::*;

   logic signed [DW-1:0] dx, dy, ux1, uy1, ux2, uy2;
   logic signed [PW-1:0] pa1_ff, pb1_ff, pa2_ff, pb2_ff;
   logic signed [CRW-1:0] c1, c2;
   logic [CRW-1:0] mag1, mag2;
   logic [SQ_W-1:0] m1_ff, m2_ff;
   logic big_ff, big_sq_ff;
   logic [2*SQ_W-1:0] sq1_ff, sq2_ff;
   logic [MW-1:0] metric;
   logic [TW-1:0] thr;
   logic v1_ff, v2_ff, v3_ff;
   flat_res_type res_ff;

   // differences against the start point
   assign dx  = $signed({seg.x3[CW-1], seg.x3}) - $signed({seg.x0[CW-1], seg.x0});
   assign dy  = $signed({seg.y3[CW-1], seg.y3}) - $signed({seg.y0[CW-1], seg.y0});
   assign ux1 = $signed({seg.x1[CW-1], seg.x1}) - $signed({seg.x0[CW-1], seg.x0});
   assign uy1 = $signed({seg.y1[CW-1], seg.y1}) - $signed({seg.y0[CW-1], seg.y0});
   assign ux2 = $signed({seg.x2[CW-1], seg.x2}) - $signed({seg.x0[CW-1], seg.x0});
   assign uy2 = $signed({seg.y2[CW-1], seg.y2}) - $signed({seg.y0[CW-1], seg.y0});

   // stage 1: partial products of both cross products
   always_ff @(posedge clock) begin
      pa1_ff <= ux1 * dy;
      pb1_ff <= uy1 * dx;
      pa2_ff <= ux2 * dy;
      pb2_ff <= uy2 * dx;
   end

   // stage 2: cross magnitudes, anything at or above 2^SQ_W cannot be flat
   assign c1   = $signed({pa1_ff[PW-1], pa1_ff}) - $signed({pb1_ff[PW-1], pb1_ff});
   assign c2   = $signed({pa2_ff[PW-1], pa2_ff}) - $signed({pb2_ff[PW-1], pb2_ff});
   assign mag1 = c1[CRW-1] ? CRW'(-c1) : CRW'(c1);
   assign mag2 = c2[CRW-1] ? CRW'(-c2) : CRW'(c2);

   always_ff @(posedge clock) begin
      m1_ff  <= mag1[SQ_W-1:0];
      m2_ff  <= mag2[SQ_W-1:0];
      big_ff <= (|mag1[CRW-1:SQ_W]) | (|mag2[CRW-1:SQ_W]);
   end

   // stage 3: squares
   always_ff @(posedge clock) begin
      sq1_ff    <= m1_ff * m1_ff;
      sq2_ff    <= m2_ff * m2_ff;
      big_sq_ff <= big_ff;
   end

   // stage 4: metric against scaled limit
   assign metric = {1'b0, sq1_ff} + {1'b0, sq2_ff};
   assign thr    = {limit, {THR_SHIFT{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         res_ff <= '0;
      end else begin
         v1_ff       <= start;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
         res_ff.done <= v3_ff;
         res_ff.flat <= !big_sq_ff && (metric <= MW'(thr));
      end
   end

   assign res = res_ff;

endmodule

// ===== rtl/core/cubic_bezier_path_flattener.sv =====
// Path flattener: takes move_to, line_to, cubic_to and end_path requests with
// Q12.4 coordinates and returns polyline points with 9 fraction bits. move_to
// and line_to issue only their end point, after the old cursor point when a
// line_to finds no path open. A cubic_to walks its de Casteljau subdivision
// tree one node at a time: each tested node is issued to the 4-stage flatness
// pipeline, waits on it, and is decided in the cycle its result arrives. A
// leaf then emits its end point and pops the next pending half from the stack
// memory. A node at maximum depth skips the test and goes straight to its
// leaf. A cubic_to that finds no path open issues the old cursor point first,
// and any output stall holds the walk.
// A new request is taken only once the previous one has issued all of its
// points; a finished point may still wait in the output register meanwhile.
module cubic_bezier_path_flattener (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic signed [cbpf_pkg::IN_W-1:0]    req_end_x,
   input  logic signed [cbpf_pkg::IN_W-1:0]    req_end_y,
   input  logic signed [cbpf_pkg::IN_W-1:0]    req_ctrl1_x,
   input  logic signed [cbpf_pkg::IN_W-1:0]    req_ctrl1_y,
   input  logic signed [cbpf_pkg::IN_W-1:0]    req_ctrl2_x,
   input  logic signed [cbpf_pkg::IN_W-1:0]    req_ctrl2_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cbpf_pkg::OUT_W-1:0]   rsp_point_x,
   output logic signed [cbpf_pkg::OUT_W-1:0]   rsp_point_y,
   output logic                                rsp_path_start,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbpf_pkg::LIMIT_W-1:0]        csr_flatness_limit
);
   import cbpf_pkg::*;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in, req_cmd_e;
   logic path_open_ff, path_open_in;
   logic signed [IN_W-1:0] cursor_x_ff, cursor_x_in, cursor_y_ff, cursor_y_in;
   logic [LIMIT_W-1:0] limit_ff;
   seg_type seg_ff, seg_in, first_half, second_half;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [SP_W-1:0] sp_ff, sp_in;

   stack_entry_type stack_mem [STACK_DEPTH];
   stack_entry_type rd_ff;
   logic push, pop;

   logic test_start;
   flat_res_type flat_res;

   logic can_emit, emit_go, emit_start, emit_last;
   coord_type emit_x, emit_y;
   logic rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic rsp_start_ff, rsp_last_ff;

   coord_type xab, xbc, xcd, xabc, xbcd, xm;
   coord_type yab, ybc, ycd, yabc, ybcd, ym;

   function automatic coord_type half_sum(coord_type a, coord_type b);
      logic signed [CW:0] s;
      s = $signed({a[CW-1], a}) + $signed({b[CW-1], b});
      return s[CW:1];
   endfunction

   assign req_cmd_e = cmd_type'(req_cmd);
   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // flatness register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_flatness_limit;
      end
   end

   // de casteljau split of the current segment
   always_comb begin
      xab  = half_sum(seg_ff.x0, seg_ff.x1);
      xbc  = half_sum(seg_ff.x1, seg_ff.x2);
      xcd  = half_sum(seg_ff.x2, seg_ff.x3);
      xabc = half_sum(xab, xbc);
      xbcd = half_sum(xbc, xcd);
      xm   = half_sum(xabc, xbcd);
      yab  = half_sum(seg_ff.y0, seg_ff.y1);
      ybc  = half_sum(seg_ff.y1, seg_ff.y2);
      ycd  = half_sum(seg_ff.y2, seg_ff.y3);
      yabc = half_sum(yab, ybc);
      ybcd = half_sum(ybc, ycd);
      ym   = half_sum(yabc, ybcd);
      first_half  = '{x0: seg_ff.x0, y0: seg_ff.y0, x1: xab, y1: yab,
                      x2: xabc, y2: yabc, x3: xm, y3: ym};
      second_half = '{x0: xm, y0: ym, x1: xbcd, y1: ybcd,
                      x2: xcd, y2: ycd, x3: seg_ff.x3, y3: seg_ff.y3};
   end

   cbpf_flat_test u_flat_test (
      .clock (clock),
      .reset (reset),
      .start (test_start),
      .seg   (seg_ff),
      .limit (limit_ff),
      .res   (flat_res)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      path_open_in = path_open_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      seg_in       = seg_ff;
      level_in     = level_ff;
      sp_in        = sp_ff;
      push         = 1'b0;
      pop          = 1'b0;
      test_start   = 1'b0;
      emit_go      = 1'b0;
      emit_x       = seg_ff.x3;
      emit_y       = seg_ff.y3;
      emit_start   = 1'b0;
      emit_last    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd_e;
               level_in = '0;
               sp_in    = '0;
               seg_in   = '{x0: {cursor_x_ff, {MAX_SUBDIV_DEPTH{1'b0}}},
                            y0: {cursor_y_ff, {MAX_SUBDIV_DEPTH{1'b0}}},
                            x1: {req_ctrl1_x, {MAX_SUBDIV_DEPTH{1'b0}}},
                            y1: {req_ctrl1_y, {MAX_SUBDIV_DEPTH{1'b0}}},
                            x2: {req_ctrl2_x, {MAX_SUBDIV_DEPTH{1'b0}}},
                            y2: {req_ctrl2_y, {MAX_SUBDIV_DEPTH{1'b0}}},
                            x3: {req_end_x, {MAX_SUBDIV_DEPTH{1'b0}}},
                            y3: {req_end_y, {MAX_SUBDIV_DEPTH{1'b0}}}};
               if (req_cmd_e == CMD_END) begin
                  path_open_in = 1'b0;
               end else begin
                  cursor_x_in  = req_end_x;
                  cursor_y_in  = req_end_y;
                  path_open_in = 1'b1;
                  if (req_cmd_e == CMD_MOVE) begin
                     state_in = S_FINAL;
                  end else if (!path_open_ff) begin
                     state_in = S_CURSOR;
                  end else if (req_cmd_e == CMD_LINE) begin
                     state_in = S_FINAL;
                  end else begin
                     state_in = S_TEST;
                  end
               end
            end
         end
         S_CURSOR: begin
            // old cursor opens the path
            if (can_emit) begin
               emit_go    = 1'b1;
               emit_x     = seg_ff.x0;
               emit_y     = seg_ff.y0;
               emit_start = 1'b1;
               state_in   = (cmd_ff == CMD_LINE) ? S_FINAL : S_TEST;
            end
         end
         S_FINAL: begin
            if (can_emit) begin
               emit_go    = 1'b1;
               emit_start = (cmd_ff == CMD_MOVE);
               emit_last  = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_TEST: begin
            if (level_ff == LVL_W'(MAX_SUBDIV_DEPTH)) begin
               state_in = S_LEAF;
            end else begin
               test_start = 1'b1;
               state_in   = S_WAIT;
            end
         end
         S_WAIT: begin
            if (flat_res.done) begin
               if (flat_res.flat) begin
                  state_in = S_LEAF;
               end else begin
                  // keep the second half for later, go on with the first
                  push     = 1'b1;
                  sp_in    = sp_ff + SP_W'(1);
                  seg_in   = first_half;
                  level_in = level_ff + LVL_W'(1);
                  state_in = S_TEST;
               end
            end
         end
         S_LEAF: begin
            if (can_emit) begin
               emit_go   = 1'b1;
               emit_last = (sp_ff == '0);
               if (sp_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  pop      = 1'b1;
                  sp_in    = sp_ff - SP_W'(1);
                  state_in = S_POP;
               end
            end
         end
         S_POP: begin
            seg_in   = rd_ff.seg;
            level_in = rd_ff.level;
            state_in = S_TEST;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         path_open_ff <= 1'b0;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         sp_ff        <= '0;
         level_ff     <= '0;
         cmd_ff       <= CMD_MOVE;
      end else begin
         state_ff     <= state_in;
         path_open_ff <= path_open_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         sp_ff        <= sp_in;
         level_ff     <= level_in;
         cmd_ff       <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   // subdivision stack memory
   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[STK_AW'(sp_ff)] <= '{level: level_ff + LVL_W'(1), seg: second_half};
      end
      if (pop) begin
         rd_ff <= stack_mem[STK_AW'(sp_ff - SP_W'(1))];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_x_ff     <= OUT_W'(emit_x);
         rsp_y_ff     <= OUT_W'(emit_y);
         rsp_start_ff <= emit_start;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_path_start = rsp_start_ff;
   assign rsp_last       = rsp_last_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack pointer beyond stack depth");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (sp_ff == '0))
      else $error("stack not empty between requests");

   assert property (@(posedge clock) disable iff (reset)
      (emit_go && emit_last) |=> (state_ff == S_IDLE))
      else $error("last point issued while work remains");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (level_ff < LVL_W'(MAX_SUBDIV_DEPTH)))
      else $error("flatness test issued at maximum depth");

endmodule

// ===== dv/cubic_bezier_path_flattener_test.sv =====
`timescale 1ns / 1ps

module cubic_bezier_path_flattener_test;
   import cbpf_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      bit                      start;
      bit                      last;
   } point_type;

   typedef struct {
      cmd_type               cmd;
      logic signed [IN_W-1:0] ex, ey, c1x, c1y, c2x, c2y;
      bit                    typed;
      logic signed [OUT_W-1:0] px, py;
      bit                    ps;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_cmd = CMD_END;
   logic signed [IN_W-1:0] req_end_x = 0, req_end_y = 0;
   logic signed [IN_W-1:0] req_ctrl1_x = 0, req_ctrl1_y = 0;
   logic signed [IN_W-1:0] req_ctrl2_x = 0, req_ctrl2_y = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [OUT_W-1:0] rsp_point_x, rsp_point_y;
   logic rsp_path_start, rsp_last;
   logic csr_valid = 0;
   logic csr_ready;
   logic [LIMIT_W-1:0] csr_flatness_limit = 0;

   // predictor state
   longint curs_x, curs_y;
   bit open_path;
   logic [LIMIT_W-1:0] flat_limit;
   point_type expected_points[$];

   int errors = 0;
   int cycles = 0;
   bit quiet = 0;

   cubic_bezier_path_flattener u_dut (.*);

   always #10 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void add_point(longint x, longint y, bit s);
      point_type p;
      p.x = x[OUT_W-1:0];
      p.y = y[OUT_W-1:0];
      p.start = s;
      p.last = 0;
      expected_points.insert(expected_points.size(), p);
   endfunction

   function automatic longint cross_mag(longint ux, longint uy, longint dx, longint dy);
      longint c;
      c = ux * dy - uy * dx;
      return c < 0 ? -c : c;
   endfunction

   // depth first de casteljau split, first half first
   function automatic void flatten_cubic(longint q0[8]);
      longint stk[8][8];
      int lvl[8];
      int sp;
      int cur_lvl;
      longint p[8], fh[8], sh[8];
      longint a, b, c, d, ab, bc, cd, abc, bcd, m;
      logic [127:0] metric, thr, c1, c2;
      stk[0] = q0;
      lvl[0] = 0;
      sp = 1;
      while (sp > 0) begin
         sp--;
         p = stk[sp];
         cur_lvl = lvl[sp];
         c1 = cross_mag(p[2] - p[0], p[3] - p[1], p[6] - p[0], p[7] - p[1]);
         c2 = cross_mag(p[4] - p[0], p[5] - p[1], p[6] - p[0], p[7] - p[1]);
         metric = c1 * c1 + c2 * c2;
         thr = {112'd0, flat_limit} << (4 * INT_FRAC - 8);
         if (cur_lvl >= MAX_SUBDIV_DEPTH || metric <= thr) begin
            add_point(p[6], p[7], 0);
         end else begin
            for (int j = 0; j < 2; j++) begin
               a = p[j]; b = p[2+j]; c = p[4+j]; d = p[6+j];
               ab = (a + b) >>> 1; bc = (b + c) >>> 1; cd = (c + d) >>> 1;
               abc = (ab + bc) >>> 1; bcd = (bc + cd) >>> 1;
               m = (abc + bcd) >>> 1;
               fh[j] = a; fh[2+j] = ab; fh[4+j] = abc; fh[6+j] = m;
               sh[j] = m; sh[2+j] = bcd; sh[4+j] = cd; sh[6+j] = d;
            end
            stk[sp] = sh; lvl[sp] = cur_lvl + 1;
            stk[sp+1] = fh; lvl[sp+1] = cur_lvl + 1;
            sp += 2;
         end
      end
   endfunction

   // expected points of one request
   function automatic void predict_request(row_type r);
      int n0;
      longint q[8];
      n0 = expected_points.size();
      if (r.cmd == CMD_END) begin
         open_path = 0;
         return;
      end
      if (r.cmd == CMD_MOVE) begin
         open_path = 1;
         add_point(longint'(r.ex) * 32, longint'(r.ey) * 32, 1);
      end else begin
         if (!open_path) begin
            add_point(curs_x * 32, curs_y * 32, 1);
            open_path = 1;
         end
         if (r.cmd == CMD_LINE) begin
            add_point(longint'(r.ex) * 32, longint'(r.ey) * 32, 0);
         end else begin
            q[0] = curs_x * 32; q[1] = curs_y * 32;
            q[2] = longint'(r.c1x) * 32; q[3] = longint'(r.c1y) * 32;
            q[4] = longint'(r.c2x) * 32; q[5] = longint'(r.c2y) * 32;
            q[6] = longint'(r.ex) * 32; q[7] = longint'(r.ey) * 32;
            flatten_cubic(q);
         end
      end
      curs_x = r.ex;
      curs_y = r.ey;
      if (expected_points.size() > n0)
         expected_points[expected_points.size()-1].last = 1;
   endfunction

   task automatic send_request(row_type r);
      point_type tp;
      int g;
      req_valid <= 1;
      req_cmd <= r.cmd;
      req_end_x <= r.ex; req_end_y <= r.ey;
      req_ctrl1_x <= r.c1x; req_ctrl1_y <= r.c1y;
      req_ctrl2_x <= r.c2x; req_ctrl2_y <= r.c2y;
      do @(posedge clock); while (req_stall);
      predict_request(r);
      if (r.typed) begin
         expected_points.delete(expected_points.size() - 1);
         tp.x = r.px; tp.y = r.py; tp.start = r.ps; tp.last = 1;
         expected_points.insert(expected_points.size(), tp);
      end
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] v);
      csr_valid <= 1;
      csr_flatness_limit <= v;
      do @(posedge clock); while (!csr_ready);
      flat_limit = v;
      csr_valid <= 0;
   endtask

   function automatic logic signed [IN_W-1:0] rand_coord(longint near);
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return IN_W'($urandom);
      if (r < 5) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      return IN_W'(near + $signed($urandom_range(0, 400)) - 200);
   endfunction

   function automatic row_type rand_row(bit noise);
      row_type r;
      int k;
      k = $urandom_range(0, 99);
      if (noise) r.cmd = cmd_type'($urandom_range(0, 3));
      else if (!open_path || k < 8) r.cmd = (k < 4) ? CMD_END : CMD_MOVE;
      else if (k < 45) r.cmd = CMD_LINE;
      else r.cmd = CMD_CUBIC;
      r.ex = rand_coord(curs_x); r.ey = rand_coord(curs_y);
      r.c1x = rand_coord(curs_x); r.c1y = rand_coord(curs_y);
      r.c2x = rand_coord(r.ex); r.c2y = rand_coord(r.ey);
      r.typed = 0; r.px = 0; r.py = 0; r.ps = 0;
      return r;
   endfunction

   // directed requests
   row_type dir_rows[] = '{
      '{CMD_LINE, 16'sd100, -16'sd100, 16'sh1234, 16'sh4321, 0, 0, 0, 0, 0, 0},
      '{CMD_MOVE, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 1, 22'sd1048544, 22'sd1048544, 1},
      '{CMD_LINE, 16'sh8000, 16'sh8000, -1, -1, -1, -1,
        1, -22'sd1048576, -22'sd1048576, 0},
      '{CMD_MOVE, 16'sh8000, 16'sh7fff, 0, 0, 0, 0, 1, -22'sd1048576, 22'sd1048544, 1},
      '{CMD_LINE, 16'sh7fff, 16'sh8000, 16'sh7fff, 0, 0, 16'sh7fff,
        1, 22'sd1048544, -22'sd1048576, 0},
      '{CMD_CUBIC, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
        0, 0, 0, 0},
      '{CMD_CUBIC, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
        0, 0, 0, 0},
      '{CMD_MOVE, 16'sd0, 16'sd0, 0, 0, 0, 0, 1, 0, 0, 1},
      '{CMD_CUBIC, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1, 0, 0, 0},
      '{CMD_CUBIC, 16'sd160, 16'sd0, 16'sd48, 16'sd0, 16'sd112, 16'sd0, 0, 0, 0, 0},
      '{CMD_CUBIC, 16'sd0, 16'sd0, 16'sd160, 16'sd320, -16'sd160, 16'sd320, 0, 0, 0, 0},
      '{CMD_END, 16'sh5555, 16'shaaaa, 16'shffff, 16'shffff, 16'shffff, 16'shffff,
        0, 0, 0, 0},
      '{CMD_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_CUBIC, 16'sd400, 16'sd400, 16'sd800, 16'sd0, 16'sd0, 16'sd800, 0, 0, 0, 0},
      '{CMD_LINE, -16'sd1, 16'sd1, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
        1, -22'sd32, 22'sd32, 0},
      '{CMD_END, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_LINE, 16'sd7, 16'sd9, 0, 0, 0, 0, 0, 0, 0, 0},
      '{CMD_MOVE, -16'sd1, -16'sd1, 0, 0, 0, 0, 1, -22'sd32, -22'sd32, 1},
      '{CMD_CUBIC, 16'sd3, -16'sd5, 16'sd1, 16'sd2, 16'sd2, -16'sd3, 0, 0, 0, 0}
   };

   // result check and receiver stall
   int stall_left = 0;
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            report("unexpected point", rsp_point_x, 0);
         end else begin
            e = expected_points.pop_front();
            if (rsp_point_x !== e.x) report("point_x", rsp_point_x, e.x);
            if (rsp_point_y !== e.y) report("point_y", rsp_point_y, e.y);
            if (rsp_path_start !== e.start) report("path_start", rsp_path_start, e.start);
            if (rsp_last !== e.last) report("last", rsp_last, e.last);
         end
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= !rsp_stall && !quiet && ($urandom_range(0, 1) != 0);
      end
   end

   // main sequence
   initial begin
      logic [LIMIT_W-1:0] limits[6];
      int lim_idx;
      curs_x = 0; curs_y = 0; open_path = 0; flat_limit = 64;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[i]) send_request(dir_rows[i]);
      wait_drained();

      limits = '{16'd0, 16'hffff, 16'd64, 16'd1, 16'd4096, 16'd0};
      for (lim_idx = 0; lim_idx < 6; lim_idx++) begin
         write_limit((lim_idx == 3) ? LIMIT_W'($urandom) : limits[lim_idx]);
         quiet = (lim_idx == 2);
         for (int n = 0; n < 40; n++)
            send_request(rand_row($urandom_range(0, 9) == 0));
         wait_drained();
      end

      if (expected_points.size() != 0)
         report("points left over", expected_points.size(), 0);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
